// ===== rtl/core/sapq_pkg.sv =====
// sapq_pkg: operation and status codes, field widths and the result type
// shared by the sorted-array priority queue sequencer and its top level
// depends on nothing
`timescale 1ns / 1ps

package sapq_pkg;

  localparam int VAL_W   = 32;
  localparam int IDX_W   = 5;
  localparam int CNTO_W  = 6;
  localparam int OP_W    = 2;
  localparam int ST_W    = 3;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [ST_W-1:0] ST_RANGE    = 3'd4;

  typedef struct packed {
    logic [CNTO_W-1:0] count;
    logic [VAL_W-1:0]  read_value;
    logic [ST_W-1:0]   status;
  } res_t;

endpackage

// ===== rtl/core/sapq_mem.sv =====
// sapq_mem: entry store, one write port and one read port with registered data
// depends on nothing
`timescale 1ns / 1ps

module sapq_mem #(
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [31:0]              wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [31:0]              rd_data_r
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/sapq_seq.sv =====
// sapq_seq: sequencer that walks the entry store for insert, delete and read
// depends on sapq_pkg, drives sapq_mem
`timescale 1ns / 1ps

module sapq_seq
  import sapq_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OP_W-1:0]          in_op,
  input  logic signed [VAL_W-1:0]  in_value,
  input  logic [IDX_W-1:0]         in_index,
  output logic                     mem_wr_en,
  output logic [$clog2(DEPTH)-1:0] mem_wr_addr,
  output logic [31:0]              mem_wr_data,
  output logic                     mem_rd_en,
  output logic [$clog2(DEPTH)-1:0] mem_rd_addr,
  input  logic [31:0]              mem_rd_data,
  output logic                     res_valid,
  input  logic                     res_free,
  output res_t                     res
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_PUT,
    S_DEL,
    S_RD,
    S_OUT
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [CW-1:0]           ptr_r, ptr_nxt;
  logic                    found_r, found_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic [ST_W-1:0]         status_r, status_nxt;
  logic [VAL_W-1:0]        rv_r, rv_nxt;

  logic [CW-1:0]           cnt_m1;
  logic [CW-1:0]           ptr_m1;
  logic [CW-1:0]           ptr_m2;
  logic [CW-1:0]           ptr_p1;
  logic [CW+IDX_W-1:0]     idx_ext;
  logic [CW+IDX_W-1:0]     cnt_ext;
  logic [AW+IDX_W-1:0]     idx_addr;
  logic [CW+CNTO_W-1:0]    cnt_out_ext;
  logic                    hit;

  assign cnt_m1      = cnt_r - CW'(1);
  assign ptr_m1      = ptr_r - CW'(1);
  assign ptr_m2      = ptr_r - CW'(2);
  assign ptr_p1      = ptr_r + CW'(1);
  assign idx_ext     = {{CW{1'b0}}, in_index};
  assign cnt_ext     = {{IDX_W{1'b0}}, cnt_r};
  assign idx_addr    = {{AW{1'b0}}, in_index};
  assign cnt_out_ext = {{CNTO_W{1'b0}}, cnt_r};
  assign hit         = found_r | (mem_rd_data == val_r);

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    ptr_nxt     = ptr_r;
    found_nxt   = found_r;
    val_nxt     = val_r;
    status_nxt  = status_r;
    rv_nxt      = rv_r;
    in_ready    = 1'b0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = ptr_r[AW-1:0];
    mem_wr_data = mem_rd_data;
    mem_rd_en   = 1'b0;
    mem_rd_addr = ptr_r[AW-1:0];
    res_valid   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          val_nxt    = in_value;
          status_nxt = ST_OK;
          rv_nxt     = '0;
          unique case (in_op)
            OP_INSERT: begin
              if (cnt_r == CW'(DEPTH)) begin
                status_nxt = ST_FULL;
                state_nxt  = S_OUT;
              end else if (cnt_r == '0) begin
                ptr_nxt   = '0;
                state_nxt = S_PUT;
              end else begin
                // walk down from the top entry, shifting while value >= entry
                mem_rd_en   = 1'b1;
                mem_rd_addr = cnt_m1[AW-1:0];
                ptr_nxt     = cnt_r;
                state_nxt   = S_INS;
              end
            end
            OP_DELETE: begin
              if (cnt_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_OUT;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = '0;
                ptr_nxt     = '0;
                found_nxt   = 1'b0;
                state_nxt   = S_DEL;
              end
            end
            OP_READ: begin
              if (idx_ext < cnt_ext) begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = idx_addr[AW-1:0];
                state_nxt   = S_RD;
              end else begin
                status_nxt = ST_RANGE;
                state_nxt  = S_OUT;
              end
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_INS: begin
        // read data is the entry at ptr - 1
        if (val_r >= $signed(mem_rd_data)) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = ptr_r[AW-1:0];
          mem_wr_data = mem_rd_data;
          ptr_nxt     = ptr_m1;
          if (ptr_r == CW'(1)) begin
            state_nxt = S_PUT;
          end else begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = ptr_m2[AW-1:0];
          end
        end else begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = ptr_r[AW-1:0];
        mem_wr_data = val_r;
        cnt_nxt     = cnt_r + CW'(1);
        state_nxt   = S_OUT;
      end
      S_DEL: begin
        // read data is the entry at ptr, entries after the hit move down
        if (found_r) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = ptr_m1[AW-1:0];
          mem_wr_data = mem_rd_data;
        end
        found_nxt = hit;
        if (ptr_r == cnt_m1) begin
          if (hit) begin
            cnt_nxt = cnt_m1;
          end else begin
            status_nxt = ST_NOTFOUND;
          end
          state_nxt = S_OUT;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = ptr_p1[AW-1:0];
          ptr_nxt     = ptr_p1;
        end
      end
      S_RD: begin
        rv_nxt    = mem_rd_data;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        res_valid = 1'b1;
        if (res_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res.status     = status_r;
  assign res.read_value = rv_r;
  assign res.count      = cnt_out_ext[CNTO_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      found_r <= found_nxt;
    end
    ptr_r    <= ptr_nxt;
    val_r    <= val_nxt;
    status_r <= status_nxt;
    rv_r     <= rv_nxt;
  end

endmodule

// ===== rtl/core/sorted_array_priority_queue.sv =====
// sorted_array_priority_queue: top level, entry store, sequencer, output register
// depends on sapq_pkg, sapq_mem, sapq_seq
`timescale 1ns / 1ps
//
// channel  dir  tdata (low bit up)                          tuser
// in_      in   value[31:0] index[36:32] zero[39:37]        operation[1:0]
// out_     out  status[2:0] read_value[34:3] count[40:35]   -
//             zero[47:41]
//
// one beat at a time; the entry store has a single read port, so the walk
// sets the time: insert walks down from the top entry, shifting each one it
// passes and reading the one it stops on; delete walks every entry; a read
// does one store read; a refused or unused operation goes straight to the result
// synchronous active-low reset clears the count and the sequencer; the
// entries themselves are not cleared and only positions below the count
// are ever read
// the result sits in an output register, a stalled out_tready holds it while
// the next beat is accepted and worked on

module sorted_array_priority_queue
  import sapq_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // value[31:0], index[36:32], zero pad
  input  logic [1:0]  in_tuser,   // operation[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // status[2:0], read_value[34:3], count[40:35], zero pad
);

  localparam int AW = $clog2(DEPTH);

  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [31:0]   mem_wr_data;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  logic [31:0]   mem_rd_data;

  logic          res_valid;
  logic          res_free;
  res_t          res;

  logic          out_valid_r;
  res_t          out_res_r;

  // output slot can take a result when empty or being drained this cycle
  assign res_free = !out_valid_r || out_tready;

  sapq_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk       (clk),
    .wr_en     (mem_wr_en),
    .wr_addr   (mem_wr_addr),
    .wr_data   (mem_wr_data),
    .rd_en     (mem_rd_en),
    .rd_addr   (mem_rd_addr),
    .rd_data_r (mem_rd_data)
  );

  sapq_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_op       (in_tuser),
    .in_value    ($signed(in_tdata[31:0])),
    .in_index    (in_tdata[36:32]),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .res_valid   (res_valid),
    .res_free    (res_free),
    .res         (res)
  );

  // output register: valid is control, payload loads with each new result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_free) begin
      out_valid_r <= res_valid;
    end
    if (res_valid && res_free) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r};

endmodule
